[rtl/lsw_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// lsw_pkg
// Shared types, constants and the arctangent table of the scan transform.
// ============================================================================
package lsw_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_DEPTH   = 24;
    localparam int ATAN_IDX_W   = $clog2(ATAN_DEPTH);

    localparam int RANGE_W  = 16;
    localparam int ANGLE_W  = 16;
    localparam int POSE_W   = 21;
    localparam int POINT_W  = 22;
    localparam int KINV_W   = 30;
    localparam int VEC_W    = 49;
    localparam int Z_W      = 32;
    localparam int FRAC_W   = 30;
    localparam int LOCAL_W  = VEC_W - FRAC_W;
    localparam int SUM_W    = POINT_W + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    localparam logic [KINV_W-1:0] KINV_Q30 = KINV_W'(652032874);

    localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POSE_X       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POSE_Y       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_POSE_HEADING = 3'd6;

    typedef struct packed {
        logic [ANGLE_W-1:0]       start_angle;
        logic [ANGLE_W-1:0]       angle_step;
        logic [RANGE_W-1:0]       min_range_mm;
        logic [RANGE_W-1:0]       max_range_mm;
        logic signed [POSE_W-1:0] pose_x_mm;
        logic signed [POSE_W-1:0] pose_y_mm;
        logic [ANGLE_W-1:0]       pose_heading;
    } cfg_t;

    typedef struct packed {
        logic               start;
        logic [RANGE_W-1:0] range_mm;
        logic [ANGLE_W-1:0] theta;
    } rot_req_t;

    typedef struct packed {
        logic                      done;
        logic signed [LOCAL_W-1:0] local_x;
        logic signed [LOCAL_W-1:0] local_y;
    } rot_rsp_t;

    function automatic logic [Z_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
        logic [Z_W-1:0] v;
        unique case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/lsw_cfg_regs.sv]
`timescale 1ns / 1ps
// ============================================================================
// lsw_cfg_regs
// Configuration register file: scan angles, range window and robot pose.
// ============================================================================
module lsw_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lsw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lsw_pkg::CFG_DATA_W-1:0] cfg_data,
    output lsw_pkg::cfg_t                  cfg
);
    import lsw_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_angle  <= '0;
            cfg_reg.angle_step   <= '0;
            cfg_reg.min_range_mm <= '0;
            cfg_reg.max_range_mm <= {RANGE_W{1'b1}};
            cfg_reg.pose_x_mm    <= '0;
            cfg_reg.pose_y_mm    <= '0;
            cfg_reg.pose_heading <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_START_ANGLE:  cfg_reg.start_angle  <= cfg_data[ANGLE_W-1:0];
                REG_ANGLE_STEP:   cfg_reg.angle_step   <= cfg_data[ANGLE_W-1:0];
                REG_MIN_RANGE:    cfg_reg.min_range_mm <= cfg_data[RANGE_W-1:0];
                REG_MAX_RANGE:    cfg_reg.max_range_mm <= cfg_data[RANGE_W-1:0];
                REG_POSE_X:       cfg_reg.pose_x_mm    <= $signed(cfg_data[POSE_W-1:0]);
                REG_POSE_Y:       cfg_reg.pose_y_mm    <= $signed(cfg_data[POSE_W-1:0]);
                REG_POSE_HEADING: cfg_reg.pose_heading <= cfg_data[ANGLE_W-1:0];
                default:          ;
            endcase
        end
    end

endmodule

[rtl/lsw_cordic.sv]
`timescale 1ns / 1ps
// ============================================================================
// lsw_cordic
// Iterative CORDIC rotator: one shared add/shift step per cycle.
// ============================================================================
module lsw_cordic (
    input  logic              clk,
    input  logic              rst_n,
    input  lsw_pkg::rot_req_t req,
    output lsw_pkg::rot_rsp_t rsp
);
    import lsw_pkg::*;

    typedef enum logic [2:0] {
        C_IDLE,
        C_LOAD,
        C_ITER,
        C_ROUND
    } cstate_t;

    cstate_t                   state_reg;
    logic [ATAN_IDX_W-1:0]     cnt_reg;
    logic [1:0]                quad_reg;
    logic [VEC_W-1:0]          mag_reg;
    logic signed [VEC_W-1:0]   x_reg;
    logic signed [VEC_W-1:0]   y_reg;
    logic signed [Z_W-1:0]     z_reg;
    logic                      done_reg;
    logic signed [LOCAL_W-1:0] ox_reg;
    logic signed [LOCAL_W-1:0] oy_reg;

    logic [ANGLE_W-1:0]              u;
    logic [13:0]                     resid;
    logic [RANGE_W+KINV_W-1:0]       prod;
    logic signed [VEC_W-1:0]         dx;
    logic signed [VEC_W-1:0]         dy;
    logic signed [Z_W-1:0]           tz;
    logic signed [VEC_W-1:0]         rx;
    logic signed [VEC_W-1:0]         ry;
    logic signed [VEC_W-1:0]         half;

    assign u     = req.theta + ANGLE_W'(8192);
    assign resid = {~u[13], u[12:0]};
    assign prod  = {{KINV_W{1'b0}}, req.range_mm} * {{RANGE_W{1'b0}}, KINV_Q30};
    assign dx    = y_reg >>> cnt_reg;
    assign dy    = x_reg >>> cnt_reg;
    assign tz    = $signed(atan_entry(cnt_reg));
    assign half  = VEC_W'(1) <<< (FRAC_W - 1);
    assign rx    = x_reg + half;
    assign ry    = y_reg + half;

    assign rsp.done    = done_reg;
    assign rsp.local_x = ox_reg;
    assign rsp.local_y = oy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                C_IDLE:
                begin
                    if (req.start)
                    begin
                        mag_reg   <= VEC_W'(prod);
                        quad_reg  <= u[15:14];
                        z_reg     <= $signed({{2{resid[13]}}, resid, 16'b0});
                        state_reg <= C_LOAD;
                    end
                end
                C_LOAD:
                begin
                    unique case (quad_reg)
                        2'd0:
                        begin
                            x_reg <= $signed(mag_reg);
                            y_reg <= '0;
                        end
                        2'd1:
                        begin
                            x_reg <= '0;
                            y_reg <= $signed(mag_reg);
                        end
                        2'd2:
                        begin
                            x_reg <= -$signed(mag_reg);
                            y_reg <= '0;
                        end
                        default:
                        begin
                            x_reg <= '0;
                            y_reg <= -$signed(mag_reg);
                        end
                    endcase
                    cnt_reg   <= '0;
                    state_reg <= C_ITER;
                end
                C_ITER:
                begin
                    if (!z_reg[Z_W-1])
                    begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - tz;
                    end
                    else
                    begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + tz;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == ATAN_IDX_W'(CORDIC_STEPS - 1))
                    begin
                        state_reg <= C_ROUND;
                    end
                end
                C_ROUND:
                begin
                    ox_reg    <= rx[VEC_W-1:FRAC_W];
                    oy_reg    <= ry[VEC_W-1:FRAC_W];
                    done_reg  <= 1'b1;
                    state_reg <= C_IDLE;
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/lidar_scan_to_world_points.sv]
`timescale 1ns / 1ps
// ============================================================================
// lidar_scan_to_world_points
// Turns laser range samples into saturated world-frame points.
// ============================================================================
// Input stream s_*: one range sample per item; tlast marks the last sample of
// a scan, tuser carries the not-finite flag and the scan-start flag.
// Output stream m_*: one point per sample; tuser is the valid flag, tlast
// copies the input tlast. Invalid samples give a zero point with tuser low.
// Configuration channel cfg_*: register index and data, always ready; write
// only while no sample is in flight.
// A valid sample passes from acceptance through S_START and S_WAIT, where the
// iterative CORDIC rotator does one shift-add step per cycle, and S_OUT into
// the output register; an invalid sample goes from acceptance straight to S_OUT.
// s_tready rises again as the output register loads; one sample is in flight
// at a time, and the output register lets the next sample enter while a point
// waits.
// When m_tready is low the finished point holds in the output register and the
// block stalls before loading the next one.
// Reset clears the beam angle, the configuration (max range to all ones) and
// empties the output register.
// ============================================================================
module lidar_scan_to_world_points (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [15:0]                    s_tdata,   // range_mm[15:0]
    input  logic [1:0]                     s_tuser,   // range_not_finite, scan_start
    input  logic                           s_tlast,   // scan_end
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [47:0]                    m_tdata,   // point_x_mm[21:0], point_y_mm[43:22]
    output logic                           m_tuser,   // point_valid
    output logic                           m_tlast,   // end_of_scan
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lsw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lsw_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lsw_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_WAIT,
        S_OUT
    } state_t;

    cfg_t     cfg;
    rot_req_t req;
    rot_rsp_t rsp;

    state_t                    state_reg;
    logic [ANGLE_W-1:0]        beam_angle_reg;
    logic [RANGE_W-1:0]        range_reg;
    logic [ANGLE_W-1:0]        theta_reg;
    logic                      valid_reg;
    logic                      end_reg;
    logic signed [POINT_W-1:0] px_reg;
    logic signed [POINT_W-1:0] py_reg;
    logic                      m_tvalid_reg;
    logic [47:0]               m_tdata_reg;
    logic                      m_tuser_reg;
    logic                      m_tlast_reg;

    logic [ANGLE_W-1:0]      angle;
    logic                    in_valid;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((1 << (POINT_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(1 << (POINT_W - 1));

    function automatic logic signed [POINT_W-1:0] sat(input logic signed [SUM_W-1:0] v);
        logic signed [POINT_W-1:0] r;
        priority if (v > SAT_MAX)
            r = SAT_MAX[POINT_W-1:0];
        else if (v < SAT_MIN)
            r = SAT_MIN[POINT_W-1:0];
        else
            r = v[POINT_W-1:0];
        return r;
    endfunction

    lsw_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lsw_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign angle    = s_tuser[1] ? cfg.start_angle : beam_angle_reg;
    assign in_valid = !s_tuser[0] && (s_tdata > cfg.min_range_mm)
                      && (s_tdata < cfg.max_range_mm);

    assign sum_x = SUM_W'(cfg.pose_x_mm) + SUM_W'(rsp.local_x);
    assign sum_y = SUM_W'(cfg.pose_y_mm) + SUM_W'(rsp.local_y);

    assign req.start    = (state_reg == S_START);
    assign req.range_mm = range_reg;
    assign req.theta    = theta_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            beam_angle_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (m_tready && (state_reg != S_OUT))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        range_reg      <= s_tdata;
                        theta_reg      <= cfg.pose_heading + angle;
                        valid_reg      <= in_valid;
                        end_reg        <= s_tlast;
                        beam_angle_reg <= angle + cfg.angle_step;
                        px_reg         <= '0;
                        py_reg         <= '0;
                        state_reg      <= in_valid ? S_START : S_OUT;
                    end
                end
                S_START:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (rsp.done)
                    begin
                        px_reg    <= sat(sum_x);
                        py_reg    <= sat(sum_y);
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {4'b0, py_reg, px_reg};
                        m_tuser_reg  <= valid_reg;
                        m_tlast_reg  <= end_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[test/lidar_scan_to_world_points_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// lidar_scan_to_world_points_tb
// Drives range samples through the scan transform and checks every point.
// A local CORDIC model tracks the beam angle and the register settings and
// predicts each point when its sample is accepted. The monitor compares each
// output item in order. Directed samples cover the window bounds, the
// not-finite flag, scan start/end and samples before any scan start. Random
// phases follow, each under its own register setting, made of well-formed
// scans mixed with random noise. Random idling runs on both streams except in
// the first random phase, with a long receiver hold-off and drains between phases.
// ============================================================================
module lidar_scan_to_world_points_tb;

    import lsw_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam longint KINV       = 652032874;
    localparam longint POINT_MAX  = 2097151;
    localparam longint POINT_MIN  = -2097152;
    localparam int     IDLE_LIMIT = 3000;
    localparam int     HOLD_AT    = 200;
    localparam int     HOLD_LEN   = 400;

    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        logic               not_finite;
        logic               scan_start;
        logic               scan_end;
    } sample_t;

    typedef struct packed {
        logic [POINT_W-1:0] x;
        logic [POINT_W-1:0] y;
        logic               valid;
        logic               eos;
    } point_t;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  s_tvalid   = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata    = '0;   // range_mm[15:0]
    logic [1:0]            s_tuser    = '0;   // range_not_finite, scan_start
    logic                  s_tlast    = 1'b0; // scan_end
    logic                  m_tvalid;
    logic                  m_tready   = 1'b0;
    logic [47:0]           m_tdata;           // point_x_mm[21:0], point_y_mm[43:22]
    logic                  m_tuser;           // point_valid
    logic                  m_tlast;           // end_of_scan
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;

    cfg_t               scan_cfg;
    logic [ANGLE_W-1:0] beam_angle;
    sample_t            pending_samples[$];
    point_t             expected_points[$];
    sample_t            offered;
    int                 src_idle_pct  = 12;
    int                 sink_idle_pct = 12;
    int                 mismatches    = 0;
    int                 points_seen   = 0;
    int                 hold_left     = 0;
    bit                 hold_used     = 1'b0;
    int                 idle_cycles   = 0;

    lidar_scan_to_world_points dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] atan_q32(input int i);
        logic [31:0] v;
        case (i)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2FA;
            15:      v = 32'h0000517D;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A30;
            19:      v = 32'h00000518;
            20:      v = 32'h0000028C;
            21:      v = 32'h00000146;
            22:      v = 32'h000000A3;
            23:      v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    task automatic rotate_beam(input logic [RANGE_W-1:0] range_mm,
                               input logic [ANGLE_W-1:0] theta,
                               output longint ox, output longint oy);
        logic [ANGLE_W-1:0] u;
        longint             a, m, x, y, z, dx, dy;
        u = theta + 16'd8192;
        a = longint'(u[13:0]) - 8192;
        m = longint'(range_mm) * KINV;
        case (u[15:14])
            2'd0:    begin x = m;  y = 0;  end
            2'd1:    begin x = 0;  y = m;  end
            2'd2:    begin x = -m; y = 0;  end
            default: begin x = 0;  y = -m; end
        endcase
        z = a * 65536;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'({32'h0, atan_q32(i)});
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'({32'h0, atan_q32(i)});
            end
        end
        ox = (x + (longint'(1) << 29)) >>> 30;
        oy = (y + (longint'(1) << 29)) >>> 30;
    endtask

    function automatic logic [POINT_W-1:0] clamp_point(input longint v);
        longint c;
        c = v;
        if (c > POINT_MAX)
            c = POINT_MAX;
        if (c < POINT_MIN)
            c = POINT_MIN;
        return c[POINT_W-1:0];
    endfunction

    task automatic predict_point(input sample_t s, output point_t p);
        logic [ANGLE_W-1:0] angle;
        longint             lx, ly;
        angle   = s.scan_start ? scan_cfg.start_angle : beam_angle;
        p.x     = '0;
        p.y     = '0;
        p.valid = 1'b0;
        p.eos   = s.scan_end;
        if (!s.not_finite && s.range_mm > scan_cfg.min_range_mm
            && s.range_mm < scan_cfg.max_range_mm)
        begin
            rotate_beam(s.range_mm, scan_cfg.pose_heading + angle, lx, ly);
            p.x     = clamp_point(longint'($signed(scan_cfg.pose_x_mm)) + lx);
            p.y     = clamp_point(longint'($signed(scan_cfg.pose_y_mm)) + ly);
            p.valid = 1'b1;
        end
        beam_angle = angle + scan_cfg.angle_step;
    endtask

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_START_ANGLE:  scan_cfg.start_angle  = data[ANGLE_W-1:0];
            REG_ANGLE_STEP:   scan_cfg.angle_step   = data[ANGLE_W-1:0];
            REG_MIN_RANGE:    scan_cfg.min_range_mm = data[RANGE_W-1:0];
            REG_MAX_RANGE:    scan_cfg.max_range_mm = data[RANGE_W-1:0];
            REG_POSE_X:       scan_cfg.pose_x_mm    = data[POSE_W-1:0];
            REG_POSE_Y:       scan_cfg.pose_y_mm    = data[POSE_W-1:0];
            REG_POSE_HEADING: scan_cfg.pose_heading = data[ANGLE_W-1:0];
            default:          ;
        endcase
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, data);
        cfg_valid <= 1'b0;
    endtask

    // upper bits are noise for the 16-bit registers
    task automatic write_short(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
        write_reg(idx, {5'($urandom), v});
    endtask

    task automatic push_sample(input int range_mm, input bit nf, input bit st, input bit en);
        sample_t s;
        s.range_mm   = range_mm[RANGE_W-1:0];
        s.not_finite = nf;
        s.scan_start = st;
        s.scan_end   = en;
        pending_samples.insert(pending_samples.size(), s);
    endtask

    task automatic drain();
        while (pending_samples.size() != 0 || s_tvalid || expected_points.size() != 0
               || m_tvalid)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic queue_scan(input int len);
        int lo, hi, r, pick;
        lo = scan_cfg.min_range_mm;
        hi = scan_cfg.max_range_mm;
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 85 && hi > lo + 1)
                r = $urandom_range(hi - 1, lo + 1);
            else if (pick < 90)
                r = ($urandom_range(1) == 0) ? lo : hi;
            else
                r = $urandom_range(65535);
            push_sample(r, $urandom_range(19) == 0, i == 0, i == len - 1);
        end
    endtask

    task automatic randomize_setup();
        logic [15:0] lo, hi;
        lo = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2000));
        hi = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(65535, 20000));
        write_short(REG_START_ANGLE, 16'($urandom));
        write_short(REG_ANGLE_STEP, ($urandom_range(1) == 0) ? 16'($urandom)
                                                            : 16'($urandom_range(400)) - 16'd200);
        write_short(REG_MIN_RANGE, lo);
        write_short(REG_MAX_RANGE, hi);
        write_reg(REG_POSE_X, 21'($urandom));
        write_reg(REG_POSE_Y, 21'($urandom));
        write_short(REG_POSE_HEADING, 16'($urandom));
    endtask

    task automatic queue_random_phase(input int count);
        int queued, len;
        queued = 0;
        while (queued < count)
        begin
            if ($urandom_range(99) < 80)
            begin
                len = $urandom_range(30, 1);
                queue_scan(len);
            end
            else
            begin
                len = $urandom_range(3, 1);
                for (int i = 0; i < len; i++)
                    push_sample($urandom_range(65535), 1'($urandom_range(1)),
                                1'($urandom_range(1)), 1'($urandom_range(1)));
            end
            queued += len;
        end
    endtask

    // driver: hold the offered item until accepted, then load the next one
    always @(posedge clk)
    begin
        point_t p;
        if (s_tvalid && s_tready)
        begin
            predict_point(offered, p);
            expected_points.insert(expected_points.size(), p);
        end
        if (!s_tvalid || s_tready)
        begin
            if (rst_n && pending_samples.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                offered = pending_samples.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= offered.range_mm;
                s_tuser  <= {offered.scan_start, offered.not_finite};
                s_tlast  <= offered.scan_end;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // monitor: compare each point with the oldest prediction, drive m_tready
    always @(posedge clk)
    begin
        point_t want;
        point_t got;
        if (m_tvalid && m_tready)
        begin
            got.x     = m_tdata[21:0];
            got.y     = m_tdata[43:22];
            got.valid = m_tuser;
            got.eos   = m_tlast;
            points_seen++;
            if (expected_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected point x=%0d y=%0d valid=%0b eos=%0b", $realtime,
                             $signed(got.x), $signed(got.y), got.valid, got.eos);
            end
            else
            begin
                want = expected_points.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: point %0d exp (%0d,%0d,%0b,%0b) got (%0d,%0d,%0b,%0b)",
                                 $realtime, points_seen, $signed(want.x), $signed(want.y),
                                 want.valid, want.eos, $signed(got.x), $signed(got.y),
                                 got.valid, got.eos);
                end
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (!hold_used && points_seen >= HOLD_AT)
        begin
            hold_used = 1'b1;
            hold_left = HOLD_LEN;
            m_tready <= 1'b0;
        end
        else
            m_tready <= rst_n && ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        scan_cfg.start_angle  = '0;
        scan_cfg.angle_step   = '0;
        scan_cfg.min_range_mm = '0;
        scan_cfg.max_range_mm = 16'hFFFF;
        scan_cfg.pose_x_mm    = '0;
        scan_cfg.pose_y_mm    = '0;
        scan_cfg.pose_heading = '0;
        beam_angle            = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset setting, no scan start yet
        push_sample(0, 0, 0, 0);
        push_sample(1, 0, 0, 0);
        push_sample(65535, 0, 0, 0);
        push_sample(65534, 0, 0, 0);
        push_sample(1000, 1, 0, 0);
        push_sample(2500, 0, 0, 1);
        drain();

        write_short(REG_START_ANGLE, 16'd16384);
        write_short(REG_ANGLE_STEP, 16'd1024);
        write_short(REG_MIN_RANGE, 16'd100);
        write_short(REG_MAX_RANGE, 16'd5000);
        write_reg(REG_POSE_X, 21'h0FFFFF);
        write_reg(REG_POSE_Y, 21'h100000);
        write_short(REG_POSE_HEADING, 16'hFFFF);
        write_reg(REG_UNUSED, 21'h1FFFFF);
        push_sample(100, 0, 1, 0);
        push_sample(101, 0, 0, 0);
        push_sample(4999, 0, 0, 0);
        push_sample(5000, 0, 0, 0);
        push_sample(3000, 1, 0, 0);
        push_sample(65535, 1, 0, 1);
        push_sample(4000, 0, 0, 0);
        push_sample(2000, 0, 1, 1);
        drain();

        write_short(REG_START_ANGLE, 16'hFFFF);
        write_short(REG_ANGLE_STEP, 16'h8000);
        write_short(REG_MIN_RANGE, 16'd0);
        write_short(REG_MAX_RANGE, 16'hFFFF);
        write_reg(REG_POSE_X, 21'h100000);
        write_reg(REG_POSE_Y, 21'h0FFFFF);
        write_short(REG_POSE_HEADING, 16'd0);
        push_sample(65534, 0, 1, 0);
        push_sample(65534, 0, 0, 0);
        push_sample(1, 0, 0, 0);
        push_sample(32768, 0, 0, 1);
        push_sample(65534, 0, 1, 1);
        drain();

        // empty windows
        write_short(REG_MIN_RANGE, 16'd3000);
        write_short(REG_MAX_RANGE, 16'd3000);
        push_sample(3000, 0, 1, 0);
        push_sample(2999, 0, 0, 1);
        drain();
        write_short(REG_MIN_RANGE, 16'd40000);
        write_short(REG_MAX_RANGE, 16'd100);
        push_sample(20000, 0, 1, 0);
        push_sample(50, 0, 0, 1);
        drain();

        for (int phase = 0; phase < 5; phase++)
        begin
            src_idle_pct  = (phase == 0) ? 0 : 12;
            sink_idle_pct = (phase == 0) ? 0 : 12;
            randomize_setup();
            queue_random_phase(120);
            drain();
        end

        repeat (40) @(posedge clk);
        mismatches += expected_points.size();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[filelist.f]
rtl/lsw_pkg.sv
rtl/lsw_cfg_regs.sv
rtl/lsw_cordic.sv
rtl/lidar_scan_to_world_points.sv
test/lidar_scan_to_world_points_tb.sv
